FILE: hdl/ir_audio_pulse_space_capture_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pulse/space capture block
// Each macro expects clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef IR_AUDIO_PULSE_SPACE_CAPTURE_ASSERT_SVH
`define IR_AUDIO_PULSE_SPACE_CAPTURE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define IRPSC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("irpsc assertion failed");

// Antecedent implies consequent at the same edge.
`define IRPSC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irpsc assertion failed");

`endif

FILE: hdl/irpsc_pkg.sv
// ---------------------------------------------------------------------------
// irpsc_pkg
// Shared types and constants of the pulse/space capture block.
// ---------------------------------------------------------------------------
package irpsc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = 32;
  localparam int PERIOD_W   = 16;
  localparam int PROD_W     = CNT_W + PERIOD_W;
  localparam int US_W       = PROD_W - 8;
  localparam int SPACE_W    = 24;
  localparam int SAMPLE_W   = 8;
  localparam int FIFO_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_Q8     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_CHANNELS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_RIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPACE_US  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT   = 3'd6;

  // polarity modes
  localparam logic [1:0] POL_AUTO = 2'd0;
  localparam logic [1:0] POL_POS  = 2'd1;
  localparam logic [1:0] POL_NEG  = 2'd2;

  localparam logic [SAMPLE_W-1:0] MIDPOINT = 8'd128;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_q8;
    logic [6:0]          noise_level;
    logic                two_channels;
    logic                use_right;
    logic [1:0]          polarity_mode;
    logic [SPACE_W-1:0]  max_space_us;
    logic [CNT_W-1:0]    count_limit;
  } cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic             is_read;
    logic             push;
    logic             pulse_flag;
    logic             check_gap;
    logic [CNT_W-1:0] operand;
  } op_t;

  typedef struct packed {
    logic detected;
    logic inverted;
  } fe_status_t;

endpackage

FILE: hdl/irpsc_ram.sv
// ---------------------------------------------------------------------------
// irpsc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module irpsc_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/irpsc_fifo.sv
// ---------------------------------------------------------------------------
// irpsc_fifo
// Short queue of classified items between front and back.
// ---------------------------------------------------------------------------
module irpsc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  irpsc_pkg::op_t  push_op,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output irpsc_pkg::op_t  head
);
  import irpsc_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  op_t              entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/irpsc_front.sv
// ---------------------------------------------------------------------------
// irpsc_front
// Channel pick, polarity learning, thresholding and run counting per sample.
// ---------------------------------------------------------------------------
module irpsc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  irpsc_pkg::cfg_t          cfg,
  input  logic                     pol_load,
  input  logic [1:0]               pol_value,
  input  logic                     accept,
  input  logic                     cmd,
  input  logic [7:0]               first_sample,
  input  logic [7:0]               second_sample,
  output irpsc_pkg::op_t           op,
  output irpsc_pkg::fe_status_t    status
);
  import irpsc_pkg::*;

  logic             inverted;
  logic             detected;
  logic             in_pulse;
  logic [CNT_W-1:0] sample_counter;
  logic [CNT_W-1:0] gap_counter;

  logic [SAMPLE_W-1:0] s;
  logic [SAMPLE_W-1:0] dev;
  logic                detect_hit;
  logic                inv_eff;
  logic                run_clear;
  logic [CNT_W-1:0]    cnt;
  logic                prev_pulse;
  logic [SAMPLE_W-1:0] lo_th;
  logic [SAMPLE_W-1:0] hi_th;
  logic                pulse;
  logic                push;
  logic [CNT_W-1:0]    gap_next;

  always_comb begin
    s = (cfg.two_channels && cfg.use_right) ? second_sample : first_sample;
    dev = (s >= MIDPOINT) ? (s - MIDPOINT) : (MIDPOINT - s);
    detect_hit = !detected && (dev > {1'b0, cfg.noise_level});
    inv_eff = detect_hit ? (s < MIDPOINT) : inverted;
    run_clear = (sample_counter > cfg.count_limit);
    cnt = run_clear ? '0 : sample_counter;
    prev_pulse = run_clear ? 1'b0 : in_pulse;
    lo_th = MIDPOINT - {1'b0, cfg.noise_level};
    hi_th = MIDPOINT + {1'b0, cfg.noise_level};
    pulse = inv_eff ? (s < lo_th) : (s > hi_th);
    push = (pulse != prev_pulse);
    if (pulse) begin
      gap_next = '0;
    end else if (&gap_counter) begin
      gap_next = gap_counter;
    end else begin
      gap_next = gap_counter + 1'b1;
    end
  end

  always_comb begin
    op.is_read    = cmd;
    op.push       = !cmd && push;
    op.pulse_flag = !pulse;
    op.check_gap  = !cmd && !pulse;
    op.operand    = push ? cnt : gap_next;
  end

  assign status.detected = detected;
  assign status.inverted = inverted;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverted       <= 1'b0;
      detected       <= 1'b0;
      in_pulse       <= 1'b0;
      sample_counter <= '0;
      gap_counter    <= '0;
    end else if (pol_load) begin
      // reload polarity; unused mode codes fall back to auto
      inverted <= (pol_value == POL_NEG);
      detected <= (pol_value == POL_POS) || (pol_value == POL_NEG);
    end else if (accept && !cmd) begin
      if (detect_hit) begin
        detected <= 1'b1;
        inverted <= inv_eff;
      end
      in_pulse       <= pulse;
      sample_counter <= push ? CNT_W'(1) : cnt + 1'b1;
      gap_counter    <= gap_next;
    end
  end

endmodule

FILE: hdl/irpsc_back.sv
// ---------------------------------------------------------------------------
// irpsc_back
// Duration scaling, ring write/read and burst-end detection, in order.
// ---------------------------------------------------------------------------
module irpsc_back #(
  parameter int RING_DEPTH    = 256,
  parameter int DURATION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  irpsc_pkg::cfg_t          cfg,
  input  logic                     q_not_empty,
  input  irpsc_pkg::op_t           q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     read_valid,
  output logic [DURATION_BITS:0]   read_value,
  output logic                     ready_res,
  output logic                     edge_written
);
  import irpsc_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int VAL_W = DURATION_BITS + 1;

  logic              advance;
  logic              valid1;
  op_t               op1;
  logic [PROD_W-1:0] prod1;

  logic [IDX_W-1:0]  read_index;
  logic [IDX_W-1:0]  write_index;
  logic [IDX_W-1:0]  read_index_next;
  logic [IDX_W-1:0]  write_index_next;

  logic [US_W-1:0]          us;
  logic [DURATION_BITS-1:0] dur;
  logic [US_W-1:0]          gap_us;
  logic                     gap_hit;
  logic                     ring_nonempty;
  logic                     do_read;
  logic                     do_write;
  logic                     rdy;
  logic [VAL_W-1:0]         ram_rdata;

  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && q_not_empty;

  // stage 1: scale count by the sample period
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (advance) begin
      valid1 <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op1   <= q_head;
      prod1 <= q_head.operand * cfg.period_q8;
    end
  end

  // stage 2: clamp, ring access, burst-end test
  always_comb begin
    us = prod1[PROD_W-1:8];
    if (|us[US_W-1:DURATION_BITS]) begin
      dur = '1;
    end else begin
      dur = us[DURATION_BITS-1:0];
    end
    // leaving a pulse means the gap count is one
    gap_us = op1.push ? US_W'(cfg.period_q8[PERIOD_W-1:8]) : us;
    gap_hit = (gap_us > US_W'(cfg.max_space_us));

    ring_nonempty = (read_index != write_index);
    do_read  = valid1 && op1.is_read && ring_nonempty;
    do_write = valid1 && op1.push;

    read_index_next = (read_index == IDX_W'(RING_DEPTH - 1)) ? '0 : read_index + 1'b1;
    write_index_next = (write_index == IDX_W'(RING_DEPTH - 1)) ? '0 : write_index + 1'b1;

    rdy = op1.check_gap && gap_hit &&
          ((do_write ? write_index_next : write_index) != read_index);
  end

  irpsc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (advance && do_write),
    .waddr (write_index),
    .wdata ({op1.pulse_flag, dur}),
    .re    (advance),
    .raddr (read_index),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index   <= '0;
      write_index  <= '0;
      out_valid    <= 1'b0;
      read_valid   <= 1'b0;
      ready_res    <= 1'b0;
      edge_written <= 1'b0;
    end else if (advance) begin
      out_valid    <= valid1;
      read_valid   <= do_read;
      ready_res    <= valid1 && rdy;
      edge_written <= do_write;
      if (do_read) begin
        read_index <= read_index_next;
      end
      if (do_write) begin
        write_index <= write_index_next;
      end
    end
  end

  assign read_value = read_valid ? ram_rdata : '0;

endmodule

FILE: hdl/ir_audio_pulse_space_capture.sv
// An accepted item passes through the queue, then the multiply stage, then the
//   ring/output stage; one item per cycle sustained while m_tready does not stall.
// Durations are scaled by the single 32x16 period multiplier, pipelined once.
// Reset: synchronous; clears counters, ring indexes, polarity state and
//   queue, and loads the default register values. Ring contents are left as is.
// ---------------------------------------------------------------------------
// ir_audio_pulse_space_capture
// Captures pulse/space durations from an 8-bit audio stream into a ring.
// ---------------------------------------------------------------------------
module ir_audio_pulse_space_capture #(
  parameter int RING_DEPTH    = 256,
  parameter int DURATION_BITS = 24
) (
  input  logic                                           clk,
  input  logic                                           rst,
  // configuration write port
  input  logic                                           cfg_we,
  input  logic [irpsc_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [irpsc_pkg::CFG_DATA_W-1:0]               cfg_data,
  // input stream
  input  logic                                           s_tvalid,
  output logic                                           s_tready,
  input  logic [15:0]                                    s_tdata,  // first_sample, second_sample
  input  logic                                           s_tuser,  // cmd
  // result stream
  output logic                                           m_tvalid,
  input  logic                                           m_tready,
  // read_valid, read_value, ready_res, edge_written
  output logic [((DURATION_BITS+4+7)/8)*8-1:0]           m_tdata
);
  import irpsc_pkg::*;

  localparam int OUT_W = ((DURATION_BITS + 4 + 7) / 8) * 8;

  cfg_t       cfg;
  op_t        fe_op;
  op_t        q_head;
  fe_status_t fe_status;
  logic       accept;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  logic       pol_load;

  logic                     read_valid;
  logic [DURATION_BITS:0]   read_value;
  logic                     ready_res;
  logic                     edge_written;

  // register file; to be written only while idle: the user must keep to this, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_q8     <= 16'd5805;
      cfg.noise_level   <= 7'd10;
      cfg.two_channels  <= 1'b0;
      cfg.use_right     <= 1'b0;
      cfg.polarity_mode <= POL_AUTO;
      cfg.max_space_us  <= 24'd10000;
      cfg.count_limit   <= 32'd195225786;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD_Q8:     cfg.period_q8     <= cfg_data[PERIOD_W-1:0];
        REG_NOISE_LEVEL:   cfg.noise_level   <= cfg_data[6:0];
        REG_TWO_CHANNELS:  cfg.two_channels  <= cfg_data[0];
        REG_USE_RIGHT:     cfg.use_right     <= cfg_data[0];
        REG_POLARITY_MODE: cfg.polarity_mode <= cfg_data[1:0];
        REG_MAX_SPACE_US:  cfg.max_space_us  <= cfg_data[SPACE_W-1:0];
        REG_COUNT_LIMIT:   cfg.count_limit   <= cfg_data[CNT_W-1:0];
        default:           cfg               <= cfg;
      endcase
    end
  end

  assign pol_load = cfg_we && (cfg_index == REG_POLARITY_MODE);
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  irpsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pol_load      (pol_load),
    .pol_value     (cfg_data[1:0]),
    .accept        (accept),
    .cmd           (s_tuser),
    .first_sample  (s_tdata[7:0]),
    .second_sample (s_tdata[15:8]),
    .op            (fe_op),
    .status        (fe_status)
  );

  irpsc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_op   (fe_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  irpsc_back #(
    .RING_DEPTH    (RING_DEPTH),
    .DURATION_BITS (DURATION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .read_valid   (read_valid),
    .read_value   (read_value),
    .ready_res    (ready_res),
    .edge_written (edge_written)
  );

  assign m_tdata = OUT_W'({edge_written, ready_res, read_value, read_valid});

`include "ir_audio_pulse_space_capture_assert.svh"

  // a read result never also reports sample activity
  `IRPSC_ASSERT_IMPLY(a_read_excl, m_tvalid && read_valid, !ready_res && !edge_written)
  // fixed polarity modes keep the front settled
  `IRPSC_ASSERT_IMPLY(a_pol_pos, cfg.polarity_mode == POL_POS,
                      fe_status.detected && !fe_status.inverted)
  `IRPSC_ASSERT_IMPLY(a_pol_neg, cfg.polarity_mode == POL_NEG,
                      fe_status.detected && fe_status.inverted)
  // an empty queue has nothing to pop
  `IRPSC_ASSERT_ALWAYS(a_no_empty_pop, !q_pop || q_not_empty)

endmodule

FILE: dv/irpsc_duration_check.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// irpsc_duration_check
// Watches the register port and both streams of the pulse/space capture
// block. It keeps its own copy of the polarity, counters and duration ring,
// works out the result word for every accepted input word, and compares
// each result word field by field with the oldest one still due.
// ---------------------------------------------------------------------------
module irpsc_duration_check #(
  parameter int RING_DEPTH    = 256,
  parameter int DURATION_BITS = 24,
  parameter int OUT_W         = ((DURATION_BITS + 4 + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [irpsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irpsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [15:0]                        s_tdata,   // first_sample, second_sample
  input  logic                               s_tuser,   // cmd
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // read_valid, read_value, ready_res, edge_written
  input  logic [OUT_W-1:0]                   m_tdata,
  output int                                 errors,
  output int                                 pending,
  output int                                 words_out,
  output int                                 pops,
  output int                                 edges,
  output int                                 readies
);
  import irpsc_pkg::*;

  localparam int WORD_BITS = DURATION_BITS + 4;
  localparam logic [63:0] DUR_MAX = (64'd1 << DURATION_BITS) - 64'd1;

  typedef struct packed {
    logic                   edge_written;
    logic                   ready_res;
    logic [DURATION_BITS:0] read_value;
    logic                   read_valid;
  } capture_word_t;

  logic [PERIOD_W-1:0]    period_q8;
  logic [6:0]             noise_level;
  logic                   two_channels;
  logic                   use_right;
  logic [1:0]             pol_mode;
  logic [SPACE_W-1:0]     max_space_us;
  logic [CNT_W-1:0]       count_limit;

  logic                   inverted;
  logic                   detected;
  logic                   in_pulse;
  logic [CNT_W-1:0]       run_len;
  logic [CNT_W-1:0]       gap_len;
  logic [DURATION_BITS:0] ring_copy [RING_DEPTH];
  int unsigned            rd_ptr;
  int unsigned            wr_ptr;

  capture_word_t          pending_words [$];

  function automatic logic [63:0] run_us(input logic [CNT_W-1:0] count);
    return ({32'd0, count} * {48'd0, period_q8}) >> 8;
  endfunction

  task automatic reload_polarity();
    if (pol_mode == POL_POS) begin
      inverted = 1'b0;
      detected = 1'b1;
    end else if (pol_mode == POL_NEG) begin
      inverted = 1'b1;
      detected = 1'b1;
    end else begin
      inverted = 1'b0;
      detected = 1'b0;
    end
  endtask

  // store the run that just ended and restart the count
  task automatic close_run(input logic pulse_flag);
    logic [63:0] us;
    us = run_us(run_len);
    if (us > DUR_MAX) us = DUR_MAX;
    ring_copy[wr_ptr] = {pulse_flag, us[DURATION_BITS-1:0]};
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    run_len = '0;
  endtask

  task automatic step_capture(input logic is_read, input logic [7:0] first,
                              input logic [7:0] second, output capture_word_t w);
    int s;
    int n;
    int dev;
    logic is_pulse;
    w = '0;
    if (is_read) begin
      if (rd_ptr != wr_ptr) begin
        w.read_valid = 1'b1;
        w.read_value = ring_copy[rd_ptr];
        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
      end
    end else begin
      s = (two_channels && use_right) ? int'(second) : int'(first);
      n = int'(noise_level);
      if (!detected) begin
        dev = (s >= 128) ? s - 128 : 128 - s;
        if (dev > n) begin
          inverted = (s < 128);
          detected = 1'b1;
        end
      end
      if (run_len > count_limit) begin
        run_len = '0;
        in_pulse = 1'b0;
      end
      is_pulse = inverted ? (s < 128 - n) : (s > 128 + n);
      if (is_pulse) begin
        if (!in_pulse) begin
          close_run(1'b0);
          w.edge_written = 1'b1;
        end
        in_pulse = 1'b1;
        gap_len = '0;
      end else begin
        if (in_pulse) begin
          close_run(1'b1);
          w.edge_written = 1'b1;
        end
        in_pulse = 1'b0;
        if (gap_len != '1) gap_len = gap_len + 1;
        if (run_us(gap_len) > {40'd0, max_space_us} && rd_ptr != wr_ptr)
          w.ready_res = 1'b1;
      end
      run_len = run_len + 1;
    end
  endtask

  always @(posedge clk) begin : watch
    capture_word_t want;
    capture_word_t got;
    if (rst) begin
      period_q8    = 16'd5805;
      noise_level  = 7'd10;
      two_channels = 1'b0;
      use_right    = 1'b0;
      pol_mode     = POL_AUTO;
      max_space_us = 24'd10000;
      count_limit  = 32'd195225786;
      reload_polarity();
      in_pulse = 1'b0;
      run_len  = '0;
      gap_len  = '0;
      rd_ptr   = 0;
      wr_ptr   = 0;
      pending_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[WORD_BITS-1:0];
        words_out++;
        if (m_tdata[OUT_W-1:WORD_BITS] != '0) begin
          $display("%0t: padding expected 0 got %0h", $time, m_tdata[OUT_W-1:WORD_BITS]);
          errors++;
        end
        if (pending_words.size() == 0) begin
          $display("%0t: result word %0h arrived with nothing due", $time, m_tdata);
          errors++;
        end else begin
          want = pending_words.pop_front();
          if (got.read_valid !== want.read_valid) begin
            $display("%0t: read_valid expected %0d got %0d", $time,
                     want.read_valid, got.read_valid);
            errors++;
          end
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %0h got %0h", $time,
                     want.read_value, got.read_value);
            errors++;
          end
          if (got.ready_res !== want.ready_res) begin
            $display("%0t: ready_res expected %0d got %0d", $time,
                     want.ready_res, got.ready_res);
            errors++;
          end
          if (got.edge_written !== want.edge_written) begin
            $display("%0t: edge_written expected %0d got %0d", $time,
                     want.edge_written, got.edge_written);
            errors++;
          end
          pops    += want.read_valid;
          edges   += want.edge_written;
          readies += want.ready_res;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIOD_Q8:     period_q8 = cfg_data[PERIOD_W-1:0];
          REG_NOISE_LEVEL:   noise_level = cfg_data[6:0];
          REG_TWO_CHANNELS:  two_channels = cfg_data[0];
          REG_USE_RIGHT:     use_right = cfg_data[0];
          REG_POLARITY_MODE: begin
            pol_mode = cfg_data[1:0];
            reload_polarity();
          end
          REG_MAX_SPACE_US:  max_space_us = cfg_data[SPACE_W-1:0];
          REG_COUNT_LIMIT:   count_limit = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        step_capture(s_tuser, s_tdata[7:0], s_tdata[15:8], want);
        pending_words.push_back(want);
      end
    end
    pending = pending_words.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives the pulse/space capture block with audio frames shaped into
// mark/space bursts, ring reads and raw noise words, over a sweep of register
// settings, with bursty input and a stalling result side. Checking is done
// by irpsc_duration_check.
// ---------------------------------------------------------------------------
module tb_top;
  import irpsc_pkg::*;

  localparam int  DURATION_BITS = 24;
  localparam int  WORD_W        = ((DURATION_BITS + 4 + 7) / 8) * 8;
  localparam int  STALL_LIMIT   = 4000;
  localparam int  PHASE_ITEMS   = 50;
  localparam int  HOLD_CYCLES   = 120;
  localparam logic CMD_SAMPLE   = 1'b0;
  localparam logic CMD_READ     = 1'b1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [WORD_W-1:0]     m_tdata;

  int errors;
  int pending;
  int words_out;
  int pops;
  int edges;
  int readies;

  // stimulus shaping: what the sender knows of the current settings
  int            noise_cur = 10;
  logic          two_cur = 1'b0;
  logic          right_cur = 1'b0;
  logic          pulse_high = 1'b1;
  logic [15:0]   period_cur = 16'd5805;
  logic [23:0]   space_cur = 24'd10000;

  int  items_sent = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  int  rx_mode = 0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  rx_cyc = 0;
  int  quiet = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  ir_audio_pulse_space_capture #(
    .RING_DEPTH    (256),
    .DURATION_BITS (DURATION_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  irpsc_duration_check #(
    .RING_DEPTH    (256),
    .DURATION_BITS (DURATION_BITS)
  ) u_capture_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .errors    (errors),
    .pending   (pending),
    .words_out (words_out),
    .pops      (pops),
    .edges     (edges),
    .readies   (readies)
  );

  // result side: long hold-off on request, otherwise the current stall pattern
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      m_tready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else if (hold_req) begin
      m_tready <= 1'b0;
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end else begin
      rx_cyc++;
      case (rx_mode)
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        2:       m_tready <= ((rx_cyc % 7) >= 3);
        default: m_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic put_word(input logic cmd, input logic [7:0] first,
                          input logic [7:0] second);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {second, first};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PERIOD_Q8:     period_cur = val[15:0];
      REG_NOISE_LEVEL:   noise_cur = int'(val[6:0]);
      REG_TWO_CHANNELS:  two_cur = val[0];
      REG_USE_RIGHT:     right_cur = val[0];
      REG_POLARITY_MODE: pulse_high = (val[1:0] == POL_POS) ? 1'b1 :
                                      (val[1:0] == POL_NEG) ? 1'b0 :
                                      1'($urandom_range(0, 1));
      REG_MAX_SPACE_US:  space_cur = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_phase(input logic [15:0] period, input logic [6:0] noise,
                            input logic two, input logic right, input logic [1:0] pol,
                            input logic [23:0] space, input logic [31:0] limit);
    write_reg(REG_PERIOD_Q8, {16'd0, period});
    write_reg(REG_NOISE_LEVEL, {25'd0, noise});
    write_reg(REG_TWO_CHANNELS, {31'd0, two});
    write_reg(REG_USE_RIGHT, {31'd0, right});
    write_reg(REG_POLARITY_MODE, {30'd0, pol});
    write_reg(REG_MAX_SPACE_US, {8'd0, space});
    write_reg(REG_COUNT_LIMIT, limit);
  endtask

  // hold the sender until every result is back, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  // marks land beyond the band on the pulse side; spaces mostly inside the band
  function automatic logic [7:0] sample_level(input bit mark);
    int lo;
    int hi;
    if (mark) begin
      if (pulse_high) begin
        lo = (129 + noise_cur > 255) ? 255 : 129 + noise_cur;
        hi = 255;
      end else begin
        lo = 0;
        hi = (127 - noise_cur < 0) ? 0 : 127 - noise_cur;
      end
    end else if ($urandom_range(0, 3) != 0) begin
      lo = 128 - noise_cur;
      hi = 128 + noise_cur;
    end else if (pulse_high) begin
      lo = 0;
      hi = 128 + noise_cur;
    end else begin
      lo = 128 - noise_cur;
      hi = 255;
    end
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic put_sample(input bit mark);
    logic [7:0] s;
    logic [7:0] other;
    s = sample_level(mark);
    other = 8'($urandom);
    if (two_cur && right_cur) put_word(CMD_SAMPLE, other, s);
    else put_word(CMD_SAMPLE, s, other);
  endtask

  task automatic run_level(input bit mark, input int n);
    repeat (n) put_sample(mark);
  endtask

  task automatic pop_words(input int n);
    repeat (n) put_word(CMD_READ, 8'($urandom), 8'($urandom));
  endtask

  // trailing space long enough to raise ready, when that is reachable cheaply
  function automatic int long_space();
    longint need;
    need = ((longint'(space_cur) + 1) * 256 + period_cur - 1) / period_cur;
    if (need > 150) return $urandom_range(20, 60);
    return int'(need) + $urandom_range(0, 4);
  endfunction

  task automatic send_burst();
    int marks;
    marks = $urandom_range(1, 8);
    repeat (marks) begin
      run_level(1'b1, $urandom_range(1, 6));
      run_level(1'b0, $urandom_range(1, 8));
    end
    run_level(1'b0, long_space());
  endtask

  task automatic run_phase(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_burst();
          pop_words($urandom_range(0, 20));
        end
        6, 7: pop_words($urandom_range(1, 12));
        default: repeat ($urandom_range(1, 4))
          put_word(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
      endcase
    end
    settle();
  endtask

  task automatic random_phase();
    logic [31:0] limit;
    limit = $urandom_range(0, 1) ? 32'($urandom_range(1, 64)) : ($urandom | 32'd1);
    load_phase(16'($urandom_range(1, 65535)), 7'($urandom_range(0, 127)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               2'($urandom_range(0, 2)), 24'($urandom_range(0, 3000)), limit);
    rx_mode = $urandom_range(0, 2);
    gaps_on = 1'($urandom_range(0, 1));
    run_phase(PHASE_ITEMS);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: empty read, band edges, auto polarity, first runs
    rx_mode = 1;
    put_word(CMD_READ, 8'h00, 8'hFF);
    put_word(CMD_SAMPLE, 8'd128, 8'd0);
    put_word(CMD_SAMPLE, 8'd138, 8'd255);
    put_word(CMD_SAMPLE, 8'd118, 8'd0);
    put_word(CMD_SAMPLE, 8'd139, 8'd0);
    put_word(CMD_SAMPLE, 8'd255, 8'd0);
    put_word(CMD_SAMPLE, 8'd0, 8'd255);
    put_word(CMD_SAMPLE, 8'd117, 8'd255);
    put_word(CMD_SAMPLE, 8'd138, 8'd255);
    put_word(CMD_SAMPLE, 8'd255, 8'd0);
    put_word(CMD_SAMPLE, 8'd0, 8'd255);
    pop_words(5);
    settle();

    // 1 us samples; receiver holds off while the sender keeps going
    load_phase(16'd256, 7'd10, 1'b0, 1'b0, POL_POS, 24'd20, 32'hFFFF_FFFF);
    rx_mode = 1;
    gaps_on = 1'b1;
    hold_req = 1'b1;
    send_burst();
    run_phase(PHASE_ITEMS);

    load_phase(16'hFFFF, 7'd0, 1'b1, 1'b1, POL_NEG, 24'hFF_FFFF, 32'd1);
    rx_mode = 2;
    gaps_on = 1'b0;
    run_phase(PHASE_ITEMS);

    load_phase(16'd1, 7'd127, 1'b1, 1'b0, POL_AUTO, 24'd0, 32'd20);
    rx_mode = 0;
    gaps_on = 1'b1;
    run_phase(PHASE_ITEMS);

    load_phase(16'd5805, 7'd40, 1'b0, 1'b1, POL_AUTO, 24'd100, 32'd1000);
    rx_mode = 1;
    run_phase(PHASE_ITEMS);

    load_phase(16'd300, 7'd5, 1'b1, 1'b1, POL_POS, 24'd50, 32'd7);
    rx_mode = 2;
    run_phase(PHASE_ITEMS);

    random_phase();
    random_phase();

    // overrun the ring without reading, then drain what is left
    load_phase(16'd512, 7'd20, 1'b0, 1'b0, POL_POS, 24'd1000, 32'hFFFF_FFFF);
    rx_mode = 1;
    repeat (140) begin
      put_sample(1'b1);
      put_sample(1'b0);
    end
    pop_words(40);
    settle();

    $display("run: %0d input words, %0d result words, %0d ring pops, %0d edges, %0d ready",
             items_sent, words_out, pops, edges, readies);
    $display("run: all three polarity modes, both channels, long output hold-off, ring overrun");
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
